// ===== sv/postfix_expression_evaluator_core_assert.svh =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core_assert.svh
// Assertion macros used by the evaluator core RTL.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH

// same-cycle implication
`define PEE_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// pee_pkg
// Shared constants and types of the postfix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pee_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // character codes
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ADD  = 8'h2B;
    localparam logic [7:0] CH_SUB  = 8'h2D;
    localparam logic [7:0] CH_MUL  = 8'h2A;
    localparam logic [7:0] CH_DIV  = 8'h2F;

    typedef logic [1:0] t_op;
    localparam t_op OP_ADD = 2'd0;
    localparam t_op OP_SUB = 2'd1;
    localparam t_op OP_MUL = 2'd2;
    localparam t_op OP_DIV = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_UNDERFLOW = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;
    localparam t_status ST_DIVZERO   = 2'd3;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic div_zero;
    } t_alu_rsp;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stk_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_stk_stat;

endpackage

`default_nettype wire

// ===== sv/postfix_expression_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core
// Postfix expression evaluator on an 8-bit two's-complement stack.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s side): one expression character per item in tdata,
//   tlast set on the final character. + - * / are operators; any other
//   byte pushes (byte - 48) wrapped to 8 bits.
//   Output stream (m side): one item per expression, value and status,
//   status 0 ok, 1 underflow, 2 overflow (push dropped), 3 divide by zero.
//   The first error of an expression sticks until its result enters the result register.
// Timing:
//   One item is in flight at a time; o_s_tready is high only when idle.
//   Operand: accept, then push. Add/sub: pop right, read, pop left, read,
//   start the ALU, wait for it, push. Mul/div run the eight
//   shift-and-add or restore steps of the shared ALU. A last character
//   adds a final pop, a memory read and a result load; the result shows on o_m_tvalid the cycle after the load.
//   Stack memory is single ported with a registered read: each pop takes
//   a pop state and then a read state.
// Reset: synchronous, active low; empties the stack, clears status and the
//   output valid. Stack contents and output data need no clearing.
// Stall: the result register holds until taken; a new expression may
//   be accepted meanwhile and waits only when its own result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "postfix_expression_evaluator_core_assert.svh"

module postfix_expression_evaluator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] symbol
    input  wire logic        i_s_tlast,   // last
    // result items
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // [7:0] value, [9:8] status, [15:10] zero
);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_POPR = 4'd1;  // pop right operand
    localparam logic [3:0] S_GETR = 4'd2;
    localparam logic [3:0] S_POPL = 4'd3;  // pop left operand
    localparam logic [3:0] S_GETL = 4'd4;
    localparam logic [3:0] S_EXEC = 4'd5;  // start ALU
    localparam logic [3:0] S_WAIT = 4'd6;
    localparam logic [3:0] S_PUSH = 4'd7;
    localparam logic [3:0] S_FINP = 4'd8;  // final pop
    localparam logic [3:0] S_FING = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10; // load result register

    logic [3:0]           r_state;
    logic [3:0]           n_state;
    pee_pkg::t_status     r_err;
    pee_pkg::t_status     n_err;
    logic                 r_last;
    pee_pkg::t_op         r_op;
    logic [7:0]           r_val;
    logic [7:0]           r_lhs;
    logic [7:0]           r_rhs;
    logic                 r_m_valid;
    logic [7:0]           r_m_value;
    pee_pkg::t_status     r_m_status;

    logic                 w_accept;
    logic                 w_is_op;
    pee_pkg::t_op         w_op;
    logic                 w_out_free;

    pee_pkg::t_stk_cmd    w_stk_cmd;
    pee_pkg::t_stk_stat   w_stk_stat;
    logic [7:0]           w_pop_data;
    pee_pkg::t_alu_req    w_alu_req;
    pee_pkg::t_alu_rsp    w_alu_rsp;
    logic signed [7:0]    w_alu_res;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;

    // operator decode
    always_comb begin
        w_is_op = 1'b1;
        case (i_s_tdata)
            pee_pkg::CH_ADD: w_op = pee_pkg::OP_ADD;
            pee_pkg::CH_SUB: w_op = pee_pkg::OP_SUB;
            pee_pkg::CH_MUL: w_op = pee_pkg::OP_MUL;
            pee_pkg::CH_DIV: w_op = pee_pkg::OP_DIV;
            default: begin
                w_op    = pee_pkg::OP_ADD;
                w_is_op = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state         = r_state;
        n_err           = r_err;
        w_stk_cmd       = '0;
        w_alu_req.start = 1'b0;
        w_alu_req.op    = r_op;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_is_op ? S_POPR : S_PUSH;
                end
            end
            S_POPR, S_POPL, S_FINP: begin
                w_stk_cmd.pop = 1'b1;
                if (w_stk_stat.empty && r_err == pee_pkg::ST_OK) begin
                    n_err = pee_pkg::ST_UNDERFLOW;
                end
                n_state = r_state + 4'd1;
            end
            S_GETR: n_state = S_POPL;
            S_GETL: n_state = S_EXEC;
            S_EXEC: begin
                w_alu_req.start = 1'b1;
                n_state         = S_WAIT;
            end
            S_WAIT: begin
                if (w_alu_rsp.done) begin
                    if (w_alu_rsp.div_zero && r_err == pee_pkg::ST_OK) begin
                        n_err = pee_pkg::ST_DIVZERO;
                    end
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                w_stk_cmd.push = 1'b1;
                if (w_stk_stat.full && r_err == pee_pkg::ST_OK) begin
                    n_err = pee_pkg::ST_OVERFLOW;
                end
                n_state = r_last ? S_FINP : S_IDLE;
            end
            S_FING: n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    w_stk_cmd.clear = 1'b1;
                    n_err           = pee_pkg::ST_OK;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_err     <= pee_pkg::ST_OK;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
            if (r_state == S_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_s_tlast;
            r_op   <= w_op;
            r_val  <= i_s_tdata - pee_pkg::CH_ZERO;
        end
        if (r_state == S_GETR) begin
            r_rhs <= w_pop_data;
        end
        if (r_state == S_GETL) begin
            r_lhs <= w_pop_data;
        end
        if (r_state == S_WAIT && w_alu_rsp.done) begin
            r_val <= w_alu_res;
        end
        if (r_state == S_FING) begin
            r_val <= w_pop_data;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_m_value  <= r_val;
            r_m_status <= r_err;
        end
    end

    pee_stack u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_stk_cmd),
        .i_push_data (r_val),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_stk_stat)
    );

    pee_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_lhs    (r_lhs),
        .i_rhs    (r_rhs),
        .o_result (w_alu_res),
        .o_rsp    (w_alu_rsp)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'b000000, r_m_status, r_m_value};

    `PEE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !o_s_tready, "ready after accept")
    `PEE_ASSERT_NEXT(a_clear_after_result, i_clk, i_rst_n, (r_state == S_OUT) && (n_state == S_IDLE), (r_err == pee_pkg::ST_OK) && w_stk_stat.empty && o_m_tvalid, "state not cleared after result")
    `PEE_ASSERT_IMPLY(a_alu_done_in_wait, i_clk, i_rst_n, w_alu_rsp.done, r_state == S_WAIT, "ALU done outside wait state")

endmodule

`default_nettype wire

// ===== sv/pee_alu.sv =====
// ----------------------------------------------------------------------------
// pee_alu
// Iterative 8-bit add/sub/mul/div around one shared add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_alu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pee_pkg::t_alu_req i_req,
    input  wire logic signed [7:0] i_lhs,
    input  wire logic signed [7:0] i_rhs,
    output logic signed [7:0]      o_result,
    output pee_pkg::t_alu_rsp      o_rsp
);

    logic          r_busy;
    logic          r_done;
    logic [2:0]    r_cnt;
    pee_pkg::t_op  r_op;
    logic          r_neg;
    logic          r_dz;
    logic [7:0]    r_a;
    logic [7:0]    r_b;
    logic [7:0]    r_acc;
    logic [7:0]    r_res;

    logic          w_sub;
    logic [8:0]    w_x;
    logic [9:0]    w_sum;
    logic [7:0]    n_acc;
    logic [7:0]    n_b;
    logic [7:0]    w_final;
    logic [7:0]    w_abs_l;
    logic [7:0]    w_abs_r;
    logic          w_short;

    assign w_abs_l = i_lhs[7] ? 8'(-i_lhs) : 8'(i_lhs);
    assign w_abs_r = i_rhs[7] ? 8'(-i_rhs) : 8'(i_rhs);
    assign w_short = (i_req.op == pee_pkg::OP_ADD) || (i_req.op == pee_pkg::OP_SUB);

    // shared adder: acc +/- a, or shifted remainder - divisor
    assign w_sub = (r_op == pee_pkg::OP_SUB) || (r_op == pee_pkg::OP_DIV);
    assign w_x   = (r_op == pee_pkg::OP_DIV) ? {r_acc, r_b[7]} : {1'b0, r_acc};
    assign w_sum = {1'b0, w_x} + (w_sub ? ~{2'b00, r_a} : {2'b00, r_a}) + 10'(w_sub);

    always_comb begin
        n_acc = r_acc;
        n_b   = r_b;
        case (r_op)
            pee_pkg::OP_ADD, pee_pkg::OP_SUB: begin
                n_acc = w_sum[7:0];
            end
            pee_pkg::OP_MUL: begin
                if (r_b[0]) begin
                    n_acc = w_sum[7:0];
                end
                n_b = {1'b0, r_b[7:1]};
            end
            default: begin
                // restoring step, no borrow keeps the difference
                if (!w_sum[9]) begin
                    n_acc = w_sum[7:0];
                end else begin
                    n_acc = w_x[7:0];
                end
                n_b = {r_b[6:0], ~w_sum[9]};
            end
        endcase
    end

    always_comb begin
        if (r_op == pee_pkg::OP_DIV) begin
            if (r_dz) begin
                w_final = 8'h00;
            end else if (r_neg) begin
                w_final = 8'(-n_b);
            end else begin
                w_final = n_b;
            end
        end else begin
            w_final = n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= w_short ? 3'd7 : 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_op  <= i_req.op;
            r_neg <= i_lhs[7] ^ i_rhs[7];
            r_dz  <= (i_rhs == 8'sd0);
            case (i_req.op)
                pee_pkg::OP_ADD, pee_pkg::OP_SUB: begin
                    r_acc <= i_lhs;
                    r_a   <= i_rhs;
                    r_b   <= '0;
                end
                pee_pkg::OP_MUL: begin
                    r_acc <= '0;
                    r_a   <= i_lhs;
                    r_b   <= i_rhs;
                end
                default: begin
                    r_acc <= '0;
                    r_a   <= w_abs_r;
                    r_b   <= w_abs_l;
                end
            endcase
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= n_b;
            if (r_op == pee_pkg::OP_MUL) begin
                r_a <= {r_a[6:0], 1'b0};
            end
            if (r_cnt == 3'd7) begin
                r_res <= w_final;
            end
        end
    end

    assign o_result      = r_res;
    assign o_rsp.done     = r_done;
    assign o_rsp.div_zero = r_done && r_dz && (r_op == pee_pkg::OP_DIV);

endmodule

`default_nettype wire

// ===== sv/pee_stack.sv =====
// ----------------------------------------------------------------------------
// pee_stack
// Operand stack: single-port memory, fill count, registered pop data.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_stack (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pee_pkg::t_stk_cmd i_cmd,
    input  wire logic [7:0]        i_push_data,
    output logic [7:0]             o_pop_data,
    output pee_pkg::t_stk_stat     o_stat
);

    logic [7:0]                 r_mem [pee_pkg::STACK_DEPTH];
    logic [7:0]                 r_rdata;
    logic                       r_rd_ok;
    logic [pee_pkg::CNT_W-1:0]  r_cnt;
    logic [pee_pkg::CNT_W-1:0]  w_cnt_dec;
    logic [pee_pkg::ADDR_W-1:0] w_wr_addr;
    logic [pee_pkg::ADDR_W-1:0] w_rd_addr;
    logic                       w_empty;
    logic                       w_full;

    assign w_empty   = (r_cnt == '0);
    assign w_full    = (r_cnt == pee_pkg::CNT_W'(pee_pkg::STACK_DEPTH));
    assign w_cnt_dec = r_cnt - 1'b1;
    assign w_wr_addr = r_cnt[pee_pkg::ADDR_W-1:0];
    assign w_rd_addr = w_cnt_dec[pee_pkg::ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !w_full) begin
            r_mem[w_wr_addr] <= i_push_data;
        end
        if (i_cmd.pop) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_rd_ok <= i_cmd.pop && !w_empty;
            if (i_cmd.clear) begin
                r_cnt <= '0;
            end else if (i_cmd.push && !w_full) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.pop && !w_empty) begin
                r_cnt <= w_cnt_dec;
            end
        end
    end

    // underflowed pop reads as zero
    assign o_pop_data   = r_rd_ok ? r_rdata : 8'h00;
    assign o_stat.empty = w_empty;
    assign o_stat.full  = w_full;

endmodule

`default_nettype wire

// ===== tb/sv/postfix_expression_evaluator_core_test.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_core_test
// Self-checking bench for the postfix evaluator: directed expressions that
// hit every operator, underflow and divide by zero, then random well-formed,
// broken, noise and deep expressions with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1750;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 40;

    typedef logic [7:0] t_sym_q [$];

    // ------------------------------------------------------------------
    // Scoreboard: a stack machine that tracks the block item by item and
    // keeps the results it should produce, oldest first.
    // ------------------------------------------------------------------
    class rpn_scoreboard;
        typedef struct packed {
            logic [7:0]       value;
            pee_pkg::t_status status;
        } t_expr_result;

        logic [7:0]       stack_mem [pee_pkg::STACK_DEPTH];
        int unsigned      stack_fill;
        pee_pkg::t_status sticky_status;
        t_expr_result     expected_results [$];
        int unsigned      error_count;

        function new();
            stack_fill    = 0;
            sticky_status = pee_pkg::ST_OK;
            error_count   = 0;
        endfunction

        static function bit is_operator(logic [7:0] sym);
            return (sym == pee_pkg::CH_ADD) || (sym == pee_pkg::CH_SUB) ||
                   (sym == pee_pkg::CH_MUL) || (sym == pee_pkg::CH_DIV);
        endfunction

        // only the first error of an expression is kept
        function void flag_error(pee_pkg::t_status code);
            if (sticky_status == pee_pkg::ST_OK)
                sticky_status = code;
        endfunction

        function void push_byte(logic [7:0] v);
            if (stack_fill >= pee_pkg::STACK_DEPTH) begin
                flag_error(pee_pkg::ST_OVERFLOW);
            end else begin
                stack_mem[stack_fill] = v;
                stack_fill++;
            end
        endfunction

        // empty pop reads as zero and leaves the count at zero
        function logic [7:0] pop_byte();
            if (stack_fill == 0) begin
                flag_error(pee_pkg::ST_UNDERFLOW);
                return 8'h00;
            end
            stack_fill--;
            return stack_mem[stack_fill];
        endfunction

        function void note_symbol(logic [7:0] sym, logic last);
            int         lhs;
            int         rhs;
            int         res;
            logic [7:0] top;
            if (is_operator(sym)) begin
                rhs = $signed(pop_byte());
                lhs = $signed(pop_byte());
                case (sym)
                    pee_pkg::CH_ADD: res = lhs + rhs;
                    pee_pkg::CH_SUB: res = lhs - rhs;
                    pee_pkg::CH_MUL: res = lhs * rhs;
                    default: begin
                        if (rhs == 0) begin
                            flag_error(pee_pkg::ST_DIVZERO);
                            res = 0;
                        end else begin
                            res = lhs / rhs;   // truncates; -128 / -1 wraps below
                        end
                    end
                endcase
                push_byte(res[7:0]);
            end else begin
                push_byte(sym - pee_pkg::CH_ZERO);
            end
            if (last) begin
                top = pop_byte();
                expected_results.push_back('{top, sticky_status});
                stack_fill    = 0;
                sticky_status = pee_pkg::ST_OK;
            end
        endfunction

        function void check_result(logic [15:0] data);
            t_expr_result want;
            if (expected_results.size() == 0) begin
                $error("result item with no expression pending: tdata %h", data);
                error_count++;
                return;
            end
            want = expected_results.pop_front();
            if (data[7:0] !== want.value) begin
                $error("value: expected %0d, got %0d", $signed(want.value), $signed(data[7:0]));
                error_count++;
            end
            if (data[9:8] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, data[9:8]);
                error_count++;
            end
            if (data[15:10] !== 6'd0) begin
                $error("pad: expected 0, got %0d", data[15:10]);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT and its stimulus
    // ------------------------------------------------------------------
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;   // [7:0] symbol
    logic        i_s_tlast  = 1'b0;    // last
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;            // [7:0] value, [9:8] status, [15:10] zero

    rpn_scoreboard sb = new();

    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned cycle_count = 0;

    postfix_expression_evaluator_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One item per call. Bursts of random length; between bursts valid
    // drops for a random gap (sometimes none, so long unbroken runs occur).
    task automatic send_symbol(input logic [7:0] sym, input logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= sym;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_symbol(sym, last);
        items_sent++;
    endtask

    // last goes with the final character
    task automatic send_expr(input t_sym_q syms);
        foreach (syms[k])
            send_symbol(syms[k], k == syms.size() - 1);
    endtask

    // hold the input off until every pending result has been taken
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] rand_operand();
        logic [7:0] sym;
        if ($urandom_range(0, 3) != 0)
            return pee_pkg::CH_ZERO + 8'($urandom_range(0, 9));
        do sym = 8'($urandom_range(0, 255)); while (rpn_scoreboard::is_operator(sym));
        return sym;
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 3))
            0:       return pee_pkg::CH_ADD;
            1:       return pee_pkg::CH_SUB;
            2:       return pee_pkg::CH_MUL;
            default: return pee_pkg::CH_DIV;
        endcase
    endfunction

    // Valid RPN: operators only when two operands are on the stack.
    function automatic t_sym_q build_valid_expr(int unsigned n_operands);
        t_sym_q      syms;
        int unsigned depth   = 0;
        int unsigned opd_left = n_operands;
        int unsigned ops_left = n_operands - 1;
        while (opd_left != 0 || ops_left != 0) begin
            if (depth >= 2 && ops_left != 0 && (opd_left == 0 || $urandom_range(0, 1) == 1)) begin
                syms.push_back(rand_operator());
                depth--;
                ops_left--;
            end else begin
                syms.push_back(rand_operand());
                depth++;
                opd_left--;
            end
        end
        return syms;
    endfunction

    // Operator-heavy sequences that pop past the bottom of the stack.
    function automatic t_sym_q build_broken_expr();
        t_sym_q syms;
        repeat ($urandom_range(1, 6))
            syms.push_back(($urandom_range(0, 2) != 0) ? rand_operator() : rand_operand());
        return syms;
    endfunction

    function automatic t_sym_q build_noise_expr();
        t_sym_q syms;
        repeat ($urandom_range(1, 6))
            syms.push_back(8'($urandom_range(0, 255)));
        return syms;
    endfunction

    // Fills the stack to near or past its depth; past it, pushes are dropped.
    function automatic t_sym_q build_deep_expr(int unsigned n_operands);
        t_sym_q syms;
        repeat (n_operands)
            syms.push_back(rand_operand());
        if ($urandom_range(0, 1) == 1)
            syms.push_back(rand_operator());
        return syms;
    endfunction

    // Result side stalls on its own pattern: modes change at random intervals
    // between always ready, coin flip, rarely ready and a square wave.
    logic [1:0]  stall_mode  = 2'd0;
    int unsigned stall_phase = 0;

    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            stall_mode  <= 2'($urandom_range(0, 3));
            stall_phase <= $urandom_range(50, 300);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            2'd0:    i_m_tready <= 1'b1;
            2'd1:    i_m_tready <= 1'($urandom_range(0, 1));
            2'd2:    i_m_tready <= ($urandom_range(0, 7) == 0);
            default: i_m_tready <= stall_phase[2];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata);
    end

    // hard stop; a correct run needs a small fraction of this
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int unsigned kind;
        bit          mid_drained;

        mid_drained = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_expr('{8'h00, 8'hFF, pee_pkg::CH_ADD});            // byte extremes: -48 + -49
        send_expr('{"7", "8", pee_pkg::CH_MUL});
        send_expr('{"9", "5", pee_pkg::CH_SUB, "2", pee_pkg::CH_DIV});
        send_expr('{pee_pkg::CH_SUB});                           // both operands from empty stack
        send_expr('{"5", "0", pee_pkg::CH_DIV});                 // divide by zero
        // -128 / -1 wraps to -128
        send_expr('{8'hB0, "0", "1", pee_pkg::CH_SUB, pee_pkg::CH_DIV});
        // div-zero status sticks over underflow
        send_expr('{"0", "0", pee_pkg::CH_DIV, pee_pkg::CH_SUB});
        send_expr('{"1", "2", "3"});                             // entries under the top dropped
        drain_results();

        // random; the first one overflows the stack for sure
        send_expr(build_deep_expr(pee_pkg::STACK_DEPTH + 2));
        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
                send_expr(build_valid_expr(($urandom_range(0, 9) == 0) ?
                                           $urandom_range(9, 24) : $urandom_range(1, 8)));
            else if (kind < 82)
                send_expr(build_broken_expr());
            else if (kind < 99)
                send_expr(build_noise_expr());
            else
                send_expr(build_deep_expr($urandom_range(pee_pkg::STACK_DEPTH - 2,
                                                         pee_pkg::STACK_DEPTH + 4)));
            if (!mid_drained && items_sent >= ITEM_TARGET / 2) begin
                mid_drained = 1'b1;
                drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
